// ----- hw/rtl/tpc_pkg.sv -----
// Shared types and constants for the triangle plane clipper.
package tpc_pkg;

    localparam int CW        = 32;            // coordinate width, Q16.16
    localparam int DW        = 67;            // plane distance width, units of 2^-32
    localparam int QW        = 32;            // fraction bits of t
    localparam int DIST_LAT  = 3;             // distance lane stages
    localparam int ISECT_LAT = 1 + QW + 3;    // setup, divider, interpolation
    localparam int ADDR_W    = 5;

    typedef logic [CW-1:0]        t_coord;
    typedef logic [2:0][CW-1:0]   t_vtx;      // [0] x, [1] y, [2] z
    typedef logic signed [DW-1:0] t_dist;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ALL  = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [1:0] cnt;
    } t_meta;

    localparam logic [2:0] REG_PP_X = 3'd0;
    localparam logic [2:0] REG_PP_Y = 3'd1;
    localparam logic [2:0] REG_PP_Z = 3'd2;
    localparam logic [2:0] REG_PN_X = 3'd3;
    localparam logic [2:0] REG_PN_Y = 3'd4;
    localparam logic [2:0] REG_PN_Z = 3'd5;

endpackage

// ----- hw/rtl/triangle_plane_clipper.sv -----
// Top level: clips one triangle against a configurable plane.
// Input registers, distance lanes, intersection lanes and the merge stage lie in
// turn between accept and result; a second triangle, when the input yields two,
// strobes in the next cycle. Busy is high in the cycle after each accept and
// blocks a new triangle then, so a split triangle has room for its second beat.
// Reset: synchronous, active low; clears the pipeline valids and all plane
// registers to zero. Results cannot be stalled by the receiver.
module triangle_plane_clipper
    import tpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       i_in_a_x,
    input  logic [31:0]       i_in_a_y,
    input  logic [31:0]       i_in_a_z,
    input  logic [31:0]       i_in_b_x,
    input  logic [31:0]       i_in_b_y,
    input  logic [31:0]       i_in_b_z,
    input  logic [31:0]       i_in_c_x,
    input  logic [31:0]       i_in_c_y,
    input  logic [31:0]       i_in_c_z,
    output logic              o_valid,
    output logic [31:0]       o_out_a_x,
    output logic [31:0]       o_out_a_y,
    output logic [31:0]       o_out_a_z,
    output logic [31:0]       o_out_b_x,
    output logic [31:0]       o_out_b_y,
    output logic [31:0]       o_out_b_z,
    output logic [31:0]       o_out_c_x,
    output logic [31:0]       o_out_c_y,
    output logic [31:0]       o_out_c_z,
    output logic              o_last_of_run
);

    // ---------------- configuration registers ----------------
    t_vtx       r_pp, r_pn;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp <= '0;
            r_pn <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PP_X: r_pp[0] <= pwdata;
                REG_PP_Y: r_pp[1] <= pwdata;
                REG_PP_Z: r_pp[2] <= pwdata;
                REG_PN_X: r_pn[0] <= pwdata;
                REG_PN_Y: r_pn[1] <= pwdata;
                REG_PN_Z: r_pn[2] <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PP_X: prdata = r_pp[0];
            REG_PP_Y: prdata = r_pp[1];
            REG_PP_Z: prdata = r_pp[2];
            REG_PN_X: prdata = r_pn[0];
            REG_PN_Y: prdata = r_pn[1];
            REG_PN_Z: prdata = r_pn[2];
            default:  prdata = '0;
        endcase
    end

    // ---------------- input beat ----------------
    // Take no triangle while busy, which follows each accept, so a split result
    // has room for its second beat.
    logic w_acc, r_busy, r_avld;
    t_vtx r_va, r_vb, r_vc;

    assign w_acc = start && !r_busy;
    assign busy  = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_avld <= 1'b0;
        end else begin
            r_busy <= w_acc;
            r_avld <= w_acc;
        end
        if (w_acc) begin
            r_va <= {i_in_a_z, i_in_a_y, i_in_a_x};
            r_vb <= {i_in_b_z, i_in_b_y, i_in_b_x};
            r_vc <= {i_in_c_z, i_in_c_y, i_in_c_x};
        end
    end

    // ---------------- distance lanes, one per vertex ----------------
    t_vtx  w_da_v, w_db_v, w_dc_v;
    t_dist w_da, w_db, w_dc;

    tpc_dist_lane u_dist_a (.i_clk, .i_vtx(r_va), .i_pp(r_pp), .i_pn(r_pn),
                            .o_vtx(w_da_v), .o_dist(w_da));
    tpc_dist_lane u_dist_b (.i_clk, .i_vtx(r_vb), .i_pp(r_pp), .i_pn(r_pn),
                            .o_vtx(w_db_v), .o_dist(w_db));
    tpc_dist_lane u_dist_c (.i_clk, .i_vtx(r_vc), .i_pp(r_pp), .i_pn(r_pn),
                            .o_vtx(w_dc_v), .o_dist(w_dc));

    // Track the beat alongside the distance lanes.
    logic [DIST_LAT-1:0] r_dvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else begin
            r_dvld <= {r_dvld[DIST_LAT-2:0], r_avld};
        end
    end

    // ---------------- edge selection ----------------
    // Route each clipped edge (inside start, outside end) to a lane. With all
    // three inside, lane 0 carries a and b and lane 1 carries c unchanged.
    logic [2:0] w_mask;
    logic [1:0] w_s0, w_e0, w_s1, w_e1, w_cnt;
    t_vtx       w_l0_s, w_l0_e, w_l1_s, w_l1_e;
    t_dist      w_l0_ds, w_l0_de, w_l1_ds, w_l1_de;

    function automatic t_vtx pick_v(input logic [1:0] k, input t_vtx a, input t_vtx b,
                                    input t_vtx c);
        case (k)
            2'd0:    pick_v = a;
            2'd1:    pick_v = b;
            default: pick_v = c;
        endcase
    endfunction

    function automatic t_dist pick_d(input logic [1:0] k, input t_dist a, input t_dist b,
                                     input t_dist c);
        case (k)
            2'd0:    pick_d = a;
            2'd1:    pick_d = b;
            default: pick_d = c;
        endcase
    endfunction

    assign w_mask = {!w_dc[DW-1], !w_db[DW-1], !w_da[DW-1]};

    always_comb begin
        unique case (w_mask)
            3'b001: begin w_s0 = 2'd0; w_e0 = 2'd1; w_s1 = 2'd0; w_e1 = 2'd2; w_cnt = CNT_ONE; end
            3'b010: begin w_s0 = 2'd1; w_e0 = 2'd0; w_s1 = 2'd1; w_e1 = 2'd2; w_cnt = CNT_ONE; end
            3'b100: begin w_s0 = 2'd2; w_e0 = 2'd0; w_s1 = 2'd2; w_e1 = 2'd1; w_cnt = CNT_ONE; end
            3'b011: begin w_s0 = 2'd0; w_e0 = 2'd2; w_s1 = 2'd1; w_e1 = 2'd2; w_cnt = CNT_TWO; end
            3'b101: begin w_s0 = 2'd0; w_e0 = 2'd1; w_s1 = 2'd2; w_e1 = 2'd1; w_cnt = CNT_TWO; end
            3'b110: begin w_s0 = 2'd1; w_e0 = 2'd0; w_s1 = 2'd2; w_e1 = 2'd0; w_cnt = CNT_TWO; end
            3'b111: begin w_s0 = 2'd0; w_e0 = 2'd1; w_s1 = 2'd2; w_e1 = 2'd2; w_cnt = CNT_ALL; end
            default: begin
                w_s0 = 2'd0; w_e0 = 2'd1; w_s1 = 2'd2; w_e1 = 2'd2; w_cnt = CNT_NONE;
            end
        endcase
    end

    assign w_l0_s  = pick_v(w_s0, w_da_v, w_db_v, w_dc_v);
    assign w_l0_e  = pick_v(w_e0, w_da_v, w_db_v, w_dc_v);
    assign w_l1_s  = pick_v(w_s1, w_da_v, w_db_v, w_dc_v);
    assign w_l1_e  = pick_v(w_e1, w_da_v, w_db_v, w_dc_v);
    assign w_l0_ds = pick_d(w_s0, w_da, w_db, w_dc);
    assign w_l0_de = pick_d(w_e0, w_da, w_db, w_dc);
    assign w_l1_ds = pick_d(w_s1, w_da, w_db, w_dc);
    assign w_l1_de = pick_d(w_e1, w_da, w_db, w_dc);

    // ---------------- intersection lanes ----------------
    t_vtx w_o0_s, w_o0_e, w_o0_x, w_o1_s, w_o1_e, w_o1_x;

    tpc_isect_lane u_isect_0 (.i_clk, .i_s(w_l0_s), .i_e(w_l0_e),
                              .i_ds(w_l0_ds), .i_de(w_l0_de),
                              .o_s(w_o0_s), .o_e(w_o0_e), .o_x(w_o0_x));
    tpc_isect_lane u_isect_1 (.i_clk, .i_s(w_l1_s), .i_e(w_l1_e),
                              .i_ds(w_l1_ds), .i_de(w_l1_de),
                              .o_s(w_o1_s), .o_e(w_o1_e), .o_x(w_o1_x));

    // Carry the beat and its triangle count alongside the lanes.
    t_meta r_meta [ISECT_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ISECT_LAT; i++) begin
                r_meta[i].vld <= 1'b0;
            end
        end else begin
            r_meta[0].vld <= r_dvld[DIST_LAT-1];
            for (int i = 1; i < ISECT_LAT; i++) begin
                r_meta[i].vld <= r_meta[i-1].vld;
            end
        end
        r_meta[0].cnt <= w_cnt;
        for (int i = 1; i < ISECT_LAT; i++) begin
            r_meta[i].cnt <= r_meta[i-1].cnt;
        end
    end

    // ---------------- merge and output ----------------
    t_vtx w_oa, w_ob, w_oc;

    tpc_merge u_merge (
        .i_clk, .i_rst_n,
        .i_meta (r_meta[ISECT_LAT-1]),
        .i_l0_s (w_o0_s), .i_l0_e(w_o0_e), .i_l0_x(w_o0_x),
        .i_l1_s (w_o1_s), .i_l1_x(w_o1_x),
        .o_valid(o_valid), .o_a(w_oa), .o_b(w_ob), .o_c(w_oc),
        .o_last (o_last_of_run)
    );

    assign o_out_a_x = w_oa[0];
    assign o_out_a_y = w_oa[1];
    assign o_out_a_z = w_oa[2];
    assign o_out_b_x = w_ob[0];
    assign o_out_b_y = w_ob[1];
    assign o_out_b_z = w_ob[2];
    assign o_out_c_x = w_oc[0];
    assign o_out_c_y = w_oc[1];
    assign o_out_c_z = w_oc[2];

    // ---------------- assertions ----------------
    // A split triangle delivers its closing beat in the very next cycle.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |=> o_valid && o_last_of_run)
        else $error("split triangle missing its second beat");

    // Hold busy for the cycle after each accept.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // Drop busy again in the cycle after it is raised.
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

endmodule

// ----- hw/rtl/tpc_dist_lane.sv -----
// Signed plane distance of one vertex, three pipeline stages.
module tpc_dist_lane
    import tpc_pkg::*;
(
    input  logic  i_clk,
    input  t_vtx  i_vtx,
    input  t_vtx  i_pp,
    input  t_vtx  i_pn,
    output t_vtx  o_vtx,
    output t_dist o_dist
);

    logic signed [CW:0]     r_diff [3];
    logic signed [2*CW:0]   r_prod [3];
    t_dist                  r_dist;
    t_vtx                   r_v1, r_v2, r_v3;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_diff[i] <= $signed({i_vtx[i][CW-1], i_vtx[i]}) - $signed({i_pp[i][CW-1], i_pp[i]});
            r_prod[i] <= $signed(i_pn[i]) * r_diff[i];
        end
        r_dist <= DW'(r_prod[0]) + DW'(r_prod[1]) + DW'(r_prod[2]);
        r_v1   <= i_vtx;
        r_v2   <= r_v1;
        r_v3   <= r_v2;
    end

    assign o_vtx  = r_v3;
    assign o_dist = r_dist;

endmodule

// ----- hw/rtl/tpc_isect_lane.sv -----
// Edge intersection: pipelined restoring divider for t, then interpolation.
module tpc_isect_lane
    import tpc_pkg::*;
(
    input  logic  i_clk,
    input  t_vtx  i_s,
    input  t_vtx  i_e,
    input  t_dist i_ds,
    input  t_dist i_de,
    output t_vtx  o_s,
    output t_vtx  o_e,
    output t_vtx  o_x
);

    logic [DW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    t_vtx          r_s   [QW+1];
    t_vtx          r_e   [QW+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_ds;
        r_den[0] <= i_ds - i_de;
        r_q[0]   <= '0;
        r_s[0]   <= i_s;
        r_e[0]   <= i_e;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0] w_sh;
        logic [DW:0] w_sub;
        logic        w_ge;
        assign w_sh  = {r_rem[k], 1'b0};
        assign w_sub = w_sh - {1'b0, r_den[k]};
        assign w_ge  = (w_sh >= {1'b0, r_den[k]});
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_ge ? w_sub[DW-1:0] : w_sh[DW-1:0];
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= {r_q[k][QW-2:0], w_ge};
            r_s[k+1]   <= r_s[k];
            r_e[k+1]   <= r_e[k];
        end
    end

    logic signed [CW:0]    w_diff [3];
    logic [CW:0]           r_mag  [3];
    logic                  r_neg1 [3];
    logic [QW-1:0]         r_t1;
    t_vtx                  r_s1, r_e1;
    logic [CW+QW:0]        r_prod [3];
    logic                  r_neg2 [3];
    t_vtx                  r_s2, r_e2;
    logic [CW:0]           w_q    [3];
    logic [CW:0]           w_step [3];
    t_vtx                  r_s3, r_e3, r_x3;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = $signed({r_e[QW][i][CW-1], r_e[QW][i]})
                      - $signed({r_s[QW][i][CW-1], r_s[QW][i]});
            // floor for negative steps: round the magnitude up
            w_q[i]    = r_prod[i][CW+QW:QW]
                      + {{CW{1'b0}}, (r_neg2[i] && (r_prod[i][QW-1:0] != '0))};
            w_step[i] = r_neg2[i] ? (~w_q[i] + 1'b1) : w_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_neg1[i] <= w_diff[i][CW];
            r_mag[i]  <= w_diff[i][CW] ? (~w_diff[i] + 1'b1) : w_diff[i];
            r_prod[i] <= r_mag[i] * r_t1;
            r_neg2[i] <= r_neg1[i];
            r_x3[i]   <= r_s2[i] + w_step[i][CW-1:0];
        end
        r_t1 <= r_q[QW];
        r_s1 <= r_s[QW];
        r_e1 <= r_e[QW];
        r_s2 <= r_s1;
        r_e2 <= r_e1;
        r_s3 <= r_s2;
        r_e3 <= r_e2;
    end

    assign o_s = r_s3;
    assign o_e = r_e3;
    assign o_x = r_x3;

endmodule

// ----- hw/rtl/tpc_merge.sv -----
// Merge of both lanes into output triangles, one beat per cycle.
module tpc_merge
    import tpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_meta i_meta,
    input  t_vtx  i_l0_s,
    input  t_vtx  i_l0_e,
    input  t_vtx  i_l0_x,
    input  t_vtx  i_l1_s,
    input  t_vtx  i_l1_x,
    output logic  o_valid,
    output t_vtx  o_a,
    output t_vtx  o_b,
    output t_vtx  o_c,
    output logic  o_last
);

    logic r_valid, n_valid, r_last, n_last, r_pend, n_pend;
    t_vtx r_a, n_a, r_b, n_b, r_c, n_c;
    t_vtx r_pa, n_pa, r_pb, n_pb, r_pc, n_pc;

    always_comb begin
        n_valid = 1'b0;
        n_last  = r_last;
        n_pend  = 1'b0;
        n_a = r_a;  n_b = r_b;  n_c = r_c;
        n_pa = r_pa; n_pb = r_pb; n_pc = r_pc;
        if (r_pend) begin
            n_valid = 1'b1;
            n_last  = 1'b1;
            n_a = r_pa; n_b = r_pb; n_c = r_pc;
        end
        if (i_meta.vld) begin
            case (i_meta.cnt)
                CNT_ALL: begin
                    n_valid = 1'b1; n_last = 1'b1;
                    n_a = i_l0_s; n_b = i_l0_e; n_c = i_l1_s;
                end
                CNT_ONE: begin
                    n_valid = 1'b1; n_last = 1'b1;
                    n_a = i_l0_s; n_b = i_l0_x; n_c = i_l1_x;
                end
                CNT_TWO: begin
                    n_valid = 1'b1; n_last = 1'b0;
                    n_a = i_l0_s; n_b = i_l1_s; n_c = i_l0_x;
                    n_pend = 1'b1;
                    n_pa = i_l1_s; n_pb = i_l0_x; n_pc = i_l1_x;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
        r_last <= n_last;
        r_a <= n_a;  r_b <= n_b;  r_c <= n_c;
        r_pa <= n_pa; r_pb <= n_pb; r_pc <= n_pc;
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_c     = r_c;
    assign o_last  = r_last;

endmodule

// ----- test/tb_triangle_plane_clipper.sv -----
// Self-checking testbench for the triangle plane clipper: directed table, then random phases.
module tb_triangle_plane_clipper;
    timeunit 1ns;
    timeprecision 1ps;
    import tpc_pkg::*;

    // Stop the run after this many cycles in which no beat moves on either side.
    localparam int WDOG_LIMIT     = 4000;
    // Cover the full pipeline depth plus margin; an all-outside triangle leaves no beat.
    localparam int DRAIN_CYCLES   = DIST_LAT + ISECT_LAT + 8;
    localparam int RAND_PER_PHASE = 165;
    localparam int N_PHASES       = 6;
    localparam logic [31:0] ONE   = 32'h0001_0000;   // 1.0 in Q16.16
    localparam logic [31:0] C_MAX = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN = 32'h8000_0000;

    typedef logic [2:0][31:0] vtx_t;     // [0] x, [1] y, [2] z
    typedef vtx_t [2:0]       trgl_t;    // [0] a, [1] b, [2] c

    typedef struct packed {
        trgl_t corners;
        logic  last;
    } beat_t;

    typedef struct {
        trgl_t corners;
        bit    whole;    // expectation typed in: the triangle passes unchanged
    } dir_row_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    logic        busy;
    logic [31:0] i_in_a_x = '0, i_in_a_y = '0, i_in_a_z = '0;
    logic [31:0] i_in_b_x = '0, i_in_b_y = '0, i_in_b_z = '0;
    logic [31:0] i_in_c_x = '0, i_in_c_y = '0, i_in_c_z = '0;
    logic        o_valid;
    logic [31:0] o_out_a_x, o_out_a_y, o_out_a_z;
    logic [31:0] o_out_b_x, o_out_b_y, o_out_b_z;
    logic [31:0] o_out_c_x, o_out_c_y, o_out_c_z;
    logic        o_last_of_run;

    // Plane registers as the block should hold them, indexed by register number.
    logic [31:0] plane_reg [6];
    // Clipped triangles still owed by the block, oldest first.
    beat_t       owed_tris [$];
    int          failures       = 0;
    int          quiet_cycles   = 0;
    int          sender_idle_pct = 0;
    string       vtx_name [3] = '{"a", "b", "c"};
    string       axis_name [3] = '{"x", "y", "z"};

    always #5 i_clk = ~i_clk;

    triangle_plane_clipper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .i_in_a_x      (i_in_a_x),
        .i_in_a_y      (i_in_a_y),
        .i_in_a_z      (i_in_a_z),
        .i_in_b_x      (i_in_b_x),
        .i_in_b_y      (i_in_b_y),
        .i_in_b_z      (i_in_b_z),
        .i_in_c_x      (i_in_c_x),
        .i_in_c_y      (i_in_c_y),
        .i_in_c_z      (i_in_c_z),
        .o_valid       (o_valid),
        .o_out_a_x     (o_out_a_x),
        .o_out_a_y     (o_out_a_y),
        .o_out_a_z     (o_out_a_z),
        .o_out_b_x     (o_out_b_x),
        .o_out_b_y     (o_out_b_y),
        .o_out_b_z     (o_out_b_z),
        .o_out_c_x     (o_out_c_x),
        .o_out_c_y     (o_out_c_y),
        .o_out_c_z     (o_out_c_z),
        .o_last_of_run (o_last_of_run)
    );

    // Signed distance N.(V - P) in units of 2^-32, exact; wide enough for any operands.
    function automatic logic signed [127:0] plane_distance(vtx_t p);
        logic signed [127:0] acc, nrm, pos, org;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            nrm = $signed(plane_reg[REG_PN_X + i]);
            pos = $signed(p[i]);
            org = $signed(plane_reg[REG_PP_X + i]);
            acc = acc + nrm * (pos - org);
        end
        return acc;
    endfunction

    // Walk from inside vertex s toward outside vertex e by the truncated fraction t;
    // the step is floored, so a negative delta rounds away from s.
    function automatic vtx_t cut_edge(vtx_t s, vtx_t e,
                                      logic signed [127:0] ds, logic signed [127:0] de);
        logic signed [127:0] quo, from, delta, step;
        logic [31:0]         t;
        vtx_t                r;
        quo = (ds <<< 32) / (ds - de);
        t   = quo[31:0];
        for (int i = 0; i < 3; i++) begin
            from  = $signed(s[i]);
            delta = $signed(e[i]);
            delta = delta - from;
            step  = (delta * $signed({96'd0, t})) >>> 32;
            from  = from + step;
            r[i]  = from[31:0];
        end
        return r;
    endfunction

    function automatic void owe_triangle(vtx_t p0, vtx_t p1, vtx_t p2, logic last);
        beat_t b;
        b.corners[0] = p0;
        b.corners[1] = p1;
        b.corners[2] = p2;
        b.last       = last;
        owed_tris.insert(owed_tris.size(), b);
    endfunction

    // Split the triangle by the current plane and queue what the block must emit.
    function automatic void predict_clip(trgl_t tg);
        logic signed [127:0] pdist [3];
        int   in_idx [$];
        int   out_idx [$];
        vtx_t x0, x1;
        for (int k = 0; k < 3; k++) begin
            pdist[k] = plane_distance(tg[k]);
            if (pdist[k] >= 0) in_idx.insert(in_idx.size(), k);
            else               out_idx.insert(out_idx.size(), k);
        end
        case (in_idx.size())
            CNT_ALL: owe_triangle(tg[0], tg[1], tg[2], 1'b1);
            CNT_ONE: begin
                x0 = cut_edge(tg[in_idx[0]], tg[out_idx[0]], pdist[in_idx[0]],
                              pdist[out_idx[0]]);
                x1 = cut_edge(tg[in_idx[0]], tg[out_idx[1]], pdist[in_idx[0]],
                              pdist[out_idx[1]]);
                owe_triangle(tg[in_idx[0]], x0, x1, 1'b1);
            end
            CNT_TWO: begin
                x0 = cut_edge(tg[in_idx[0]], tg[out_idx[0]], pdist[in_idx[0]],
                              pdist[out_idx[0]]);
                x1 = cut_edge(tg[in_idx[1]], tg[out_idx[0]], pdist[in_idx[1]],
                              pdist[out_idx[0]]);
                owe_triangle(tg[in_idx[0]], tg[in_idx[1]], x0, 1'b0);
                owe_triangle(tg[in_idx[1]], x0, x1, 1'b1);
            end
            default: ;    // all outside: nothing comes out
        endcase
    endfunction

    function automatic trgl_t mk(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                 logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                 logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        trgl_t tg;
        tg[0] = {az, ay, ax};
        tg[1] = {bz, by, bx};
        tg[2] = {cz, cy, cx};
        return tg;
    endfunction

    // Mostly full-range values, with a share near the origin and at the extremes.
    function automatic logic [31:0] rand_coord();
        logic [31:0] pick [4];
        pick = '{C_MAX, C_MIN, 32'h0, 32'hffff_ffff};
        case ($urandom_range(0, 9))
            6, 7, 8: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            9:       return pick[$urandom_range(0, 3)];
            default: return $urandom;
        endcase
    endfunction

    function automatic trgl_t rand_triangle();
        trgl_t tg;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                tg[k][i] = rand_coord();
        // Fold in a few degenerate triangles with a repeated corner.
        if ($urandom_range(0, 19) == 0) tg[2] = tg[0];
        return tg;
    endfunction

    // Present one triangle, hold start until the accepting edge, then book the
    // expected beats. Start stays high when the next beat follows without a gap.
    task automatic send_triangle(trgl_t tg, bit whole);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_in_a_x <= tg[0][0];
        i_in_a_y <= tg[0][1];
        i_in_a_z <= tg[0][2];
        i_in_b_x <= tg[1][0];
        i_in_b_y <= tg[1][1];
        i_in_b_z <= tg[1][2];
        i_in_c_x <= tg[2][0];
        i_in_c_y <= tg[2][1];
        i_in_c_z <= tg[2][2];
        do @(posedge i_clk); while (busy);
        if (whole) owe_triangle(tg[0], tg[1], tg[2], 1'b1);
        else       predict_clip(tg);
    endtask

    // Wait for every owed beat, then let an all-outside triangle clear the pipe.
    task automatic drain();
        while (owed_tris.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Rewrite all six plane registers while idle, plus the two unused slots,
    // which the block must ignore. Psel drops only after the last access.
    task automatic configure_plane(logic [31:0] vals [6]);
        drain();
        for (int idx = 0; idx < 8; idx++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(idx * 4);
            pwdata  <= (idx <= REG_PN_Z) ? vals[idx] : $urandom;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (idx <= REG_PN_Z) plane_reg[idx] = vals[idx];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Compare every output beat against the oldest owed triangle, field by field.
    always @(posedge i_clk) begin
        beat_t want, got;
        if (i_rst_n && o_valid) begin
            got.corners = mk(o_out_a_x, o_out_a_y, o_out_a_z, o_out_b_x, o_out_b_y,
                             o_out_b_z, o_out_c_x, o_out_c_y, o_out_c_z);
            got.last    = o_last_of_run;
            if (owed_tris.size() == 0) begin
                failures++;
                $display("%0t: unexpected triangle beat %h", $realtime, got);
            end else begin
                want = owed_tris.pop_front();
                for (int k = 0; k < 3; k++)
                    for (int i = 0; i < 3; i++)
                        if (want.corners[k][i] !== got.corners[k][i]) begin
                            failures++;
                            $display("%0t: out_%s_%s expected %h actual %h", $realtime,
                                     vtx_name[k], axis_name[i],
                                     want.corners[k][i], got.corners[k][i]);
                        end
                if (want.last !== got.last) begin
                    failures++;
                    $display("%0t: last_of_run expected %b actual %b", $realtime,
                             want.last, got.last);
                end
            end
        end
    end

    // Watchdog: any accept or output beat resets the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles = 0;
        else                             quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d beats owed", $realtime,
                     owed_tris.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        dir_row_t    rows [$];
        logic [31:0] cfg [6];
        int          n_whole;

        foreach (plane_reg[i]) plane_reg[i] = '0;

        // With the reset plane (zero normal) every vertex sits on the plane,
        // so these pass unchanged.
        rows.insert(rows.size(), '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1});
        rows.insert(rows.size(), '{mk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                      C_MAX, C_MAX), 1'b1});
        rows.insert(rows.size(), '{mk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                      C_MIN, C_MIN), 1'b1});
        rows.insert(rows.size(), '{mk(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                      32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                                      32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555), 1'b1});
        rows.insert(rows.size(), '{mk(32'hffff_ffff, C_MIN, C_MAX, 0, 32'hffff_ffff, C_MIN,
                                      C_MAX, 0, 32'hffff_ffff), 1'b1});
        n_whole = rows.size();

        // Plane x = 0, inside toward +x.
        rows.insert(rows.size(), '{mk(ONE, 0, 0, 2*ONE, ONE, 0, 3*ONE, 0, ONE), 1'b0});
        rows.insert(rows.size(), '{mk(-ONE, 0, 0, -2*ONE, ONE, 0, -3*ONE, 0, ONE), 1'b0});
        rows.insert(rows.size(), '{mk(2*ONE, ONE, 0, -ONE, 0, ONE, -3*ONE, 2*ONE, 0), 1'b0});
        rows.insert(rows.size(), '{mk(-ONE, 5, 7, -2*ONE, 9, 3, ONE, -4, 2), 1'b0});
        rows.insert(rows.size(), '{mk(ONE, ONE, 0, 3*ONE, 0, ONE, -ONE, -ONE, -ONE), 1'b0});
        rows.insert(rows.size(), '{mk(ONE, 2, 3, -3*ONE, ONE, ONE, 4*ONE, -7, 11), 1'b0});
        rows.insert(rows.size(), '{mk(0, ONE, ONE, -ONE, 0, 0, -2*ONE, ONE, 0), 1'b0});
        rows.insert(rows.size(), '{mk(-ONE, 0, 0, 0, 3, 3, 0, 5, 5), 1'b0});
        rows.insert(rows.size(), '{mk(ONE, 0, 0, -ONE, 0, 0, ONE, 0, 0), 1'b0});
        rows.insert(rows.size(), '{mk(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1, -1, 0),
                                   1'b0});
        rows.insert(rows.size(), '{mk(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, -1, 0, 0),
                                   1'b0});
        rows.insert(rows.size(), '{mk(-1, C_MAX, C_MIN, C_MAX, 0, 0, 0, C_MIN, C_MAX),
                                   1'b0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 19;
        foreach (rows[r]) begin
            if (r == n_whole) begin
                start <= 1'b0;
                cfg = '{0, 0, 0, ONE, 0, 0};
                configure_plane(cfg);
            end
            send_triangle(rows[r].corners, rows[r].whole);
        end
        start <= 1'b0;

        // Each phase moves the plane, extremes included, and sets the sender gap rate.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1:       cfg = '{rand_coord(), rand_coord(), rand_coord(), C_MIN, C_MIN, C_MIN};
                2:       cfg = '{C_MAX, C_MAX, C_MAX, C_MAX, 0, C_MIN};
                3:       cfg = '{C_MIN, C_MIN, C_MIN, $urandom, $urandom, $urandom};
                4:       cfg = '{$urandom, $urandom, $urandom, 0, 0, 0};
                default: cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            endcase
            sender_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 53 : 0;
            configure_plane(cfg);
            repeat (RAND_PER_PHASE) send_triangle(rand_triangle(), 1'b0);
            start <= 1'b0;
        end

        drain();
        if (failures == 0) $display("Test completed successfully");
        else               $display("Test completed with failures");
        $finish;
    end

endmodule
